>>> sv/server_latency_table_ranker_top_assert.svh
// Assertion macros for the server latency table ranker.
`ifndef SERVER_LATENCY_TABLE_RANKER_TOP_ASSERT_SVH
`define SERVER_LATENCY_TABLE_RANKER_TOP_ASSERT_SVH

// Implication checked every clock, off during reset.
`define SLR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("slr implication check failed");

// Next-cycle implication, off during reset.
`define SLR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("slr next-cycle check failed");

`endif

>>> sv/slr_pkg.sv
// Types and constants of the server latency table ranker.
package slr_pkg;

  localparam logic [1:0]  OP_RESERVE = 2'd0;
  localparam logic [1:0]  OP_GOOD    = 2'd1;
  localparam logic [1:0]  OP_LOAD    = 2'd2;
  localparam logic [31:0] SCORE_SCALE = 32'd1000;
  localparam logic [31:0] UNSPEC_KEY  = 32'h7fffffff;

  // Table row and list row share one layout
  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [31:0] score;
  } ent_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WR_P,
    ST_WR_J,
    ST_LIST_WR,
    ST_SORT_I,
    ST_SORT_LD,
    ST_SORT_J,
    ST_EMIT
  } state_e;

endpackage

>>> sv/server_latency_table_ranker_top.sv
// Per word: an unused op is taken and dropped, loading the unspecified address goes to
// the list without a scan, good scans the whole table; load and reserve stop at a hit.
// A final load adds the ranking of the listed addresses:
// one word out per ranked address, each held until taken.
// One word at a time, limited by the single table read port; after reset a
// clearing pass zeroes the table and no word is taken until it ends.
`include "server_latency_table_ranker_top_assert.svh"

module server_latency_table_ranker_top #(
  parameter int TABLE_DEPTH = 512,
  parameter int MAX_SERVERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [63:0] addr_high_i,
  input  logic [63:0] addr_low_i,
  input  logic [5:0]  timeout_seconds_i,
  input  logic [31:0] elapsed_ms_i,
  input  logic        last_addr_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] out_addr_high_o,
  output logic [63:0] out_addr_low_o,
  output logic [31:0] score_o,
  output logic        last_out_o
);
  import slr_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int KW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = $clog2(MAX_SERVERS);
  localparam int CW = $clog2(MAX_SERVERS + 1);
  localparam logic [AW:0] DEPTH_W = (AW + 1)'(TABLE_DEPTH);
  localparam logic [KW-1:0] DEPTH_K = KW'(TABLE_DEPTH);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_SERVERS);

  state_e state_q, state_d;

  // Latched input word
  logic [1:0]  op_q, op_d;
  logic [63:0] hi_q, hi_d, lo_q, lo_d;
  logic [31:0] sc_q, sc_d;
  logic        last_q, last_d;

  // Scan control
  logic [AW-1:0] base_q, base_d, ptr_q, ptr_d, idx_q, idx_d, hit_q, hit_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [KW-1:0] k_q, k_d;
  logic          iss_q, iss_d, cmp_last_q, cmp_last_d, swap_q, swap_d;
  ent_t          psave_q, psave_d;
  logic [31:0]   key_q, key_d;

  // List and ranking control
  logic [CW-1:0] lcnt_q, lcnt_d, n_q, n_d, i_q, i_d, j_q, j_d;
  logic [LW-1:0] lidx_q, lidx_d;
  logic          liv_q, liv_d;
  ent_t          cur_q, cur_d;

  // Output register
  logic  ovld_q, ovld_d;
  ent_t  out_q, out_d;
  logic  olast_q, olast_d;

  // Table memory ports
  ent_t          tab_mem [TABLE_DEPTH];
  ent_t          rd_q, tw_data;
  logic          tw_we, rd_en;
  logic [AW-1:0] tw_addr, rd_addr;

  // List memory ports
  ent_t          list_mem [MAX_SERVERS];
  ent_t          lrd_q, lw_data;
  logic          lw_we, lrd_en;
  logic [LW-1:0] lw_addr, lrd_addr;

  logic          match, in_zero, list_full, sort_done;
  logic [AW:0]   scan_sum;
  logic [AW-1:0] scan_addr;

  always_comb begin
    match     = iss_q && (rd_q.hi == hi_q) && (rd_q.lo == lo_q);
    in_zero   = (addr_high_i == 64'd0) && (addr_low_i == 64'd0);
    list_full = (lcnt_q == MAX_C);
    sort_done = (j_q >= n_q) && !liv_q;
    scan_sum  = {1'b0, base_q} + {1'b0, k_q[AW-1:0]};
    if (scan_sum >= DEPTH_W) begin
      scan_sum = scan_sum - DEPTH_W;
    end
    scan_addr = scan_sum[AW-1:0];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == AW'(TABLE_DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (op_i == OP_RESERVE || op_i == OP_GOOD) begin
            state_d = ST_SCAN;
          end else if (op_i == OP_LOAD) begin
            state_d = in_zero ? ST_LIST_WR : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (iss_q) begin
          if (op_q == OP_RESERVE) begin
            if (match || cmp_last_q) state_d = ST_WR_P;
          end else if (op_q == OP_GOOD) begin
            if (cmp_last_q) state_d = ST_IDLE;
          end else begin
            if (match || cmp_last_q) state_d = ST_LIST_WR;
          end
        end
      end
      ST_WR_P:    state_d = swap_q ? ST_WR_J : ST_IDLE;
      ST_WR_J:    state_d = ST_IDLE;
      ST_LIST_WR: state_d = last_q ? ST_SORT_I : ST_IDLE;
      ST_SORT_I:  state_d = ST_SORT_LD;
      ST_SORT_LD: state_d = ST_SORT_J;
      ST_SORT_J: begin
        if (sort_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!ovld_q || out_ready_i) begin
          state_d = (i_q + CW'(1) == n_q) ? ST_IDLE : ST_SORT_I;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    op_d = op_q; hi_d = hi_q; lo_d = lo_q; sc_d = sc_q; last_d = last_q;
    base_d = base_q; ptr_d = ptr_q; idx_d = idx_q; hit_d = hit_q; clr_d = clr_q;
    k_d = k_q; iss_d = 1'b0; cmp_last_d = 1'b0; swap_d = swap_q;
    psave_d = psave_q; key_d = key_q;
    lcnt_d = lcnt_q; n_d = n_q; i_d = i_q; j_d = j_q; lidx_d = lidx_q; liv_d = 1'b0;
    cur_d = cur_q;
    out_d = out_q; olast_d = olast_q;
    ovld_d = ovld_q && !out_ready_i;
    tw_we = 1'b0; tw_addr = '0; tw_data = '0;
    rd_en = 1'b0; rd_addr = '0;
    lw_we = 1'b0; lw_addr = '0; lw_data = '0;
    lrd_en = 1'b0; lrd_addr = '0;
    in_ready_o = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        tw_we   = 1'b1;
        tw_addr = clr_q;
        clr_d   = clr_q + AW'(1);
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d   = op_i;
          hi_d   = addr_high_i;
          lo_d   = addr_low_i;
          last_d = last_addr_i;
          sc_d   = (op_i == OP_GOOD) ? elapsed_ms_i
                                     : 32'(timeout_seconds_i) * SCORE_SCALE;
          base_d = (op_i == OP_RESERVE) ? ptr_q : '0;
          k_d    = '0;
          key_d  = UNSPEC_KEY;
        end
      end
      ST_SCAN: begin
        // issue one read per cycle
        if (k_q < DEPTH_K) begin
          rd_en      = 1'b1;
          rd_addr    = scan_addr;
          idx_d      = scan_addr;
          iss_d      = 1'b1;
          cmp_last_d = (k_q == DEPTH_K - KW'(1));
          k_d        = k_q + KW'(1);
        end
        // compare the word read last cycle
        if (iss_q) begin
          if (idx_q == base_q) psave_d = rd_q;
          if (op_q == OP_RESERVE) begin
            if (match) begin
              hit_d  = idx_q;
              swap_d = (idx_q != base_q);
            end else if (cmp_last_q) begin
              swap_d = 1'b0;
            end
          end else if (op_q == OP_GOOD) begin
            if (match) begin
              tw_we   = 1'b1;
              tw_addr = idx_q;
              tw_data = '{hi: hi_q, lo: lo_q, score: sc_q};
            end
          end else begin
            if (match) key_d = rd_q.score;
            else if (cmp_last_q) key_d = '0;
          end
        end
      end
      ST_WR_P: begin
        tw_we   = 1'b1;
        tw_addr = base_q;
        tw_data = '{hi: hi_q, lo: lo_q, score: sc_q};
        ptr_d   = (base_q == AW'(TABLE_DEPTH - 1)) ? '0 : base_q + AW'(1);
      end
      ST_WR_J: begin
        tw_we   = 1'b1;
        tw_addr = hit_q;
        tw_data = psave_q;
      end
      ST_LIST_WR: begin
        if (!list_full) begin
          lw_we   = 1'b1;
          lw_addr = lcnt_q[LW-1:0];
          lw_data = '{hi: hi_q, lo: lo_q, score: key_q};
          lcnt_d  = lcnt_q + CW'(1);
          n_d     = lcnt_q + CW'(1);
        end else begin
          n_d = lcnt_q;
        end
        i_d = '0;
      end
      ST_SORT_I: begin
        lrd_en   = 1'b1;
        lrd_addr = i_q[LW-1:0];
        j_d      = i_q + CW'(1);
      end
      ST_SORT_LD: begin
        cur_d = lrd_q;
      end
      ST_SORT_J: begin
        if (j_q < n_q) begin
          lrd_en   = 1'b1;
          lrd_addr = j_q[LW-1:0];
          lidx_d   = j_q[LW-1:0];
          liv_d    = 1'b1;
          j_d      = j_q + CW'(1);
        end
        // swap on a strictly smaller key
        if (liv_q && (lrd_q.score < cur_q.score)) begin
          lw_we   = 1'b1;
          lw_addr = lidx_q;
          lw_data = cur_q;
          cur_d   = lrd_q;
        end
      end
      ST_EMIT: begin
        if (!ovld_q || out_ready_i) begin
          ovld_d  = 1'b1;
          out_d   = cur_q;
          olast_d = (i_q + CW'(1) == n_q);
          i_d     = i_q + CW'(1);
          if (i_q + CW'(1) == n_q) lcnt_d = '0;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      ptr_q   <= '0;
      lcnt_q  <= '0;
      iss_q   <= 1'b0;
      liv_q   <= 1'b0;
      ovld_q  <= 1'b0;
      k_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ptr_q   <= ptr_d;
      lcnt_q  <= lcnt_d;
      iss_q   <= iss_d;
      liv_q   <= liv_d;
      ovld_q  <= ovld_d;
      k_q     <= k_d;
      i_q     <= i_d;
      j_q     <= j_d;
      n_q     <= n_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    hi_q       <= hi_d;
    lo_q       <= lo_d;
    sc_q       <= sc_d;
    last_q     <= last_d;
    base_q     <= base_d;
    idx_q      <= idx_d;
    hit_q      <= hit_d;
    cmp_last_q <= cmp_last_d;
    swap_q     <= swap_d;
    psave_q    <= psave_d;
    key_q      <= key_d;
    lidx_q     <= lidx_d;
    cur_q      <= cur_d;
    out_q      <= out_d;
    olast_q    <= olast_d;
  end

  // Table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (tw_we) tab_mem[tw_addr] <= tw_data;
    if (rd_en) rd_q <= tab_mem[rd_addr];
  end

  // List memory
  always_ff @(posedge clk_i) begin
    if (lw_we) list_mem[lw_addr] <= lw_data;
    if (lrd_en) lrd_q <= list_mem[lrd_addr];
  end

  assign out_valid_o     = ovld_q;
  assign out_addr_high_o = out_q.hi;
  assign out_addr_low_o  = out_q.lo;
  assign score_o         = out_q.score;
  assign last_out_o      = olast_q;

  `SLR_ASSERT_IMP(a_no_take_in_clear, state_q == ST_CLEAR, !in_ready_o)
  `SLR_ASSERT_IMP(a_no_write_idle, state_q == ST_IDLE, !tw_we && !lw_we)
  `SLR_ASSERT_IMP(a_count_bound, 1'b1, lcnt_q <= MAX_C)
  `SLR_ASSERT_NEXT(a_emit_clears, state_q == ST_EMIT && state_d == ST_IDLE, lcnt_q == '0)

endmodule
